FILE: rtl/crcdf_pkg.sv
// ----------------------------------------------------------------------------
// crcdf_pkg
// Shared constants and types of the CRC-checked measurement deframer.
// ----------------------------------------------------------------------------
package crcdf_pkg;

  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  localparam int unsigned POS_W = 5;
  localparam logic [POS_W-1:0] FRAME_LAST = 5'd17;
  localparam logic [POS_W-1:0] WORD1_FIRST = 5'd6;
  localparam logic [POS_W-1:0] WORD2_FIRST = 5'd12;

  // Position of a byte inside its three-byte group.
  localparam logic [1:0] SLOT_DATA0 = 2'd0;
  localparam logic [1:0] SLOT_DATA1 = 2'd1;
  localparam logic [1:0] SLOT_CRC   = 2'd2;

  localparam int unsigned WORD_W = 32;

  typedef struct packed {
    logic              valid;
    logic              crc_error;
    logic [WORD_W-1:0] humidity_bits;
    logic [WORD_W-1:0] temperature_bits;
    logic [WORD_W-1:0] co2_bits;
  } result_t;

endpackage

FILE: rtl/crcdf_crc8.sv
// ----------------------------------------------------------------------------
// crcdf_crc8
// One-byte CRC-8 update, MSB first, eight shift steps unrolled.
// ----------------------------------------------------------------------------
module crcdf_crc8 (
  input  logic [7:0] crc_in,
  input  logic [7:0] data,
  output logic [7:0] crc_out
);

  always_comb begin
    logic [7:0] c;
    c = crc_in ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ crcdf_pkg::CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

FILE: rtl/crcdf_core.sv
// ----------------------------------------------------------------------------
// crcdf_core
// Frame tracking, group CRC check, word assembly and held values.
// ----------------------------------------------------------------------------
module crcdf_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  logic [7:0]           rx_byte,
  input  logic                 frame_start,
  output crcdf_pkg::result_t   res
);

  localparam int unsigned PW = crcdf_pkg::POS_W;
  localparam int unsigned WW = crcdf_pkg::WORD_W;

  logic [PW-1:0] byte_position, byte_position_next;
  logic [1:0]    slot, slot_next;
  logic [7:0]    running_crc, running_crc_next;
  logic [WW-1:0] co2_build, co2_build_next;
  logic [WW-1:0] temperature_build, temperature_build_next;
  logic [WW-1:0] humidity_build, humidity_build_next;
  logic          frame_bad, frame_bad_next;
  logic [WW-1:0] held_co2, held_co2_next;
  logic [WW-1:0] held_temperature, held_temperature_next;
  logic [WW-1:0] held_humidity, held_humidity_next;

  logic [PW-1:0] pos;
  logic [1:0]    cur_slot;
  logic [7:0]    crc_seed, crc_upd;
  logic          is_last;

  // A start flag, or a position past the frame, restarts at byte 0.
  always_comb begin
    if (frame_start || byte_position > crcdf_pkg::FRAME_LAST) begin
      pos      = '0;
      cur_slot = crcdf_pkg::SLOT_DATA0;
    end else begin
      pos      = byte_position;
      cur_slot = slot;
    end
  end

  assign crc_seed = (cur_slot == crcdf_pkg::SLOT_DATA0) ? crcdf_pkg::CRC_INIT : running_crc;

  crcdf_crc8 u_crc (
    .crc_in  (crc_seed),
    .data    (rx_byte),
    .crc_out (crc_upd)
  );

  assign is_last = (pos == crcdf_pkg::FRAME_LAST);

  always_comb begin
    co2_build_next         = co2_build;
    temperature_build_next = temperature_build;
    humidity_build_next    = humidity_build;
    frame_bad_next         = (pos == '0) ? 1'b0 : frame_bad;
    running_crc_next       = crcdf_pkg::CRC_INIT;
    held_co2_next          = held_co2;
    held_temperature_next  = held_temperature;
    held_humidity_next     = held_humidity;

    if (cur_slot == crcdf_pkg::SLOT_CRC) begin
      if (running_crc != rx_byte) begin
        frame_bad_next = 1'b1;
      end
    end else begin
      running_crc_next = crc_upd;
      priority if (pos < crcdf_pkg::WORD1_FIRST) begin
        co2_build_next = {co2_build[WW-9:0], rx_byte};
      end else if (pos < crcdf_pkg::WORD2_FIRST) begin
        temperature_build_next = {temperature_build[WW-9:0], rx_byte};
      end else begin
        humidity_build_next = {humidity_build[WW-9:0], rx_byte};
      end
    end

    if (is_last && !frame_bad_next) begin
      held_co2_next         = co2_build_next;
      held_temperature_next = temperature_build_next;
      held_humidity_next    = humidity_build_next;
    end

    if (is_last) begin
      byte_position_next = '0;
    end else begin
      byte_position_next = pos + 1'b1;
    end
    slot_next = (cur_slot == crcdf_pkg::SLOT_CRC) ? crcdf_pkg::SLOT_DATA0 : cur_slot + 1'b1;
  end

  always_comb begin
    res.valid            = fire && is_last;
    res.crc_error        = frame_bad_next;
    res.co2_bits         = held_co2_next;
    res.temperature_bits = held_temperature_next;
    res.humidity_bits    = held_humidity_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= '0;
      slot              <= crcdf_pkg::SLOT_DATA0;
      running_crc       <= crcdf_pkg::CRC_INIT;
      co2_build         <= '0;
      temperature_build <= '0;
      humidity_build    <= '0;
      frame_bad         <= 1'b0;
      held_co2          <= '0;
      held_temperature  <= '0;
      held_humidity     <= '0;
    end else if (fire) begin
      byte_position     <= byte_position_next;
      slot              <= slot_next;
      running_crc       <= running_crc_next;
      co2_build         <= co2_build_next;
      temperature_build <= temperature_build_next;
      humidity_build    <= humidity_build_next;
      frame_bad         <= frame_bad_next;
      held_co2          <= held_co2_next;
      held_temperature  <= held_temperature_next;
      held_humidity     <= held_humidity_next;
    end
  end

endmodule

FILE: rtl/crc8_checked_measurement_deframer.sv
// ----------------------------------------------------------------------------
// crc8_checked_measurement_deframer
// Checks and unpacks 18-byte measurement frames into three float words.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries one frame byte per item; s_tuser[0] set forces
//   that byte to be frame byte 0. Each frame is six groups of two data bytes
//   and a CRC-8 byte (polynomial 0x31, seed 0xFF). After frame byte 17 one
//   item leaves on the output stream: CO2, temperature and humidity float
//   bits in m_tdata and the CRC error flag in m_tuser[0]. On a bad frame the
//   previously held words are repeated with the flag set.
//   Throughput is one byte per cycle while the receiver does not stall. A
//   byte passes an input register and the frame logic (CRC update, word
//   shift) and lands in the output register, from which a frame's result
//   leaves once its last byte has gone through the frame logic.
//   Reset clears the frame position and all held words to zero, sets the CRC
//   back to its seed and leaves both registers empty.
//   When the receiver stalls, the output register holds its item and the
//   frame logic waits; the input register then fills and s_tready drops.
// ----------------------------------------------------------------------------
module crc8_checked_measurement_deframer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic [0:0]  s_tuser,   // [0] frame_start
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // [31:0] co2_bits, [63:32] temperature_bits,
                                 // [95:64] humidity_bits
  output logic [0:0]  m_tuser    // [0] crc_error
);

  logic               in_valid;
  logic [7:0]         in_byte;
  logic               in_start;
  logic               fire;
  crcdf_pkg::result_t core_res;

  // The frame logic advances when the input register holds a byte and the output register can take a result.
  assign fire     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte  <= s_tdata;
      in_start <= s_tuser[0];
    end
  end

  crcdf_core u_core (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .rx_byte     (in_byte),
    .frame_start (in_start),
    .res         (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= core_res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (core_res.valid) begin
      m_tdata    <= {core_res.humidity_bits, core_res.temperature_bits, core_res.co2_bits};
      m_tuser[0] <= core_res.crc_error;
    end
  end

  a_res_needs_fire: assert property (@(posedge clk) disable iff (rst)
    core_res.valid |-> fire)
    else $error("frame result produced without an advancing item");

  a_start_no_result: assert property (@(posedge clk) disable iff (rst)
    (fire && in_start) |-> !core_res.valid)
    else $error("frame start byte produced a result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !fire)
    else $error("frame logic advanced while output was stalled");

endmodule
